>>> rtl/rtcrf_pkg.sv
// Shared types, register map, constants and calendar tables for the RTC register file.
package rtcrf_pkg;

  localparam int ADDRESS_SPACE_DEF = 64;
  localparam int RAM_BASE          = 14;
  localparam int CMD_DEPTH         = 4;
  localparam int RES_DEPTH         = 4;
  localparam int RES_CNT_W         = $clog2(RES_DEPTH + 1);

  localparam int DM_BIT = 2;
  localparam int PF_BIT = 6;

  localparam logic [7:0] CTRL_B_RST = 8'h03;
  localparam logic [7:0] STAT_D_RST = 8'h80;
  localparam logic [7:0] READ_FILL  = 8'hFF;
  localparam logic [7:0] FLAGS_KEEP = 8'h0F;

  localparam logic [7:0] REG_SEC     = 8'd0;
  localparam logic [7:0] REG_SEC_AL  = 8'd1;
  localparam logic [7:0] REG_MIN     = 8'd2;
  localparam logic [7:0] REG_MIN_AL  = 8'd3;
  localparam logic [7:0] REG_HOUR    = 8'd4;
  localparam logic [7:0] REG_HOUR_AL = 8'd5;
  localparam logic [7:0] REG_WDAY    = 8'd6;
  localparam logic [7:0] REG_DAY     = 8'd7;
  localparam logic [7:0] REG_MONTH   = 8'd8;
  localparam logic [7:0] REG_YEAR    = 8'd9;
  localparam logic [7:0] REG_A       = 8'd10;
  localparam logic [7:0] REG_B       = 8'd11;
  localparam logic [7:0] REG_C       = 8'd12;
  localparam logic [7:0] REG_D       = 8'd13;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_RD_DATA,
    CMD_RD_INDEX,
    CMD_WR_DATA,
    CMD_WR_INDEX,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef logic [2:0] wd_tab_t [256];
  typedef logic [2:0] mod7_tab_t [64];

  // Zeller month term, March-based months
  function automatic wd_tab_t build_month_tab();
    wd_tab_t t;
    int      mm;
    for (int m = 0; m < 256; m++) begin
      mm   = (m < 3) ? m + 12 : m;
      t[m] = 3'(((13 * (mm + 1)) / 5) % 7);
    end
    return t;
  endfunction

  // Zeller year term for 2000 + yy, less one for January and February
  function automatic wd_tab_t build_year_tab(input int dec);
    wd_tab_t t;
    int      y;
    int      k;
    int      j;
    for (int yy = 0; yy < 256; yy++) begin
      y     = 2000 + yy - dec;
      k     = y % 100;
      j     = y / 100;
      t[yy] = 3'((k + k / 4 + j / 4 + 5 * j) % 7);
    end
    return t;
  endfunction

  function automatic mod7_tab_t build_mod7_tab();
    mod7_tab_t t;
    for (int s = 0; s < 64; s++) begin
      t[s] = 3'(s % 7);
    end
    return t;
  endfunction

  localparam wd_tab_t   MONTH_TAB    = build_month_tab();
  localparam wd_tab_t   YEAR_TAB     = build_year_tab(0);
  localparam wd_tab_t   YEAR_TAB_DEC = build_year_tab(1);
  localparam mod7_tab_t MOD7_TAB     = build_mod7_tab();

  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  tens;
    logic [7:0]  units;
    p     = 16'(v) * 16'd205;
    tens  = p[15:11];
    units = v - (8'(tens) * 8'd10);
    return {tens[3:0], units[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {4'b0, b[3:0]} + ({4'b0, b[7:4]} * 8'd10);
  endfunction

  function automatic logic leap_year(input logic [7:0] yy);
    return (yy[1:0] == 2'b00) && (yy != 8'd100) && (yy != 8'd200);
  endfunction

endpackage

>>> rtl/rtcrf_fifo.sv
// Small register-based queue with occupancy count.
module rtcrf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/rtcrf_front.sv
// Front end: accepts bus and tick beats and classifies them into commands.
module rtcrf_front (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_operation,
  input  logic [1:0]        in_port,
  input  logic [7:0]        in_write_data,
  input  logic              q_full,
  output logic              q_push,
  output rtcrf_pkg::cmd_t   q_data
);

  import rtcrf_pkg::*;

  logic      cmd_vld;
  cmd_kind_t kind;

  always_comb begin
    cmd_vld = 1'b1;
    kind    = CMD_TICK;
    unique case (op_t'(in_operation))
      OP_READ:  kind = in_port[0] ? CMD_RD_INDEX : CMD_RD_DATA;
      OP_WRITE: kind = in_port[0] ? CMD_WR_INDEX : CMD_WR_DATA;
      OP_TICK:  kind = CMD_TICK;
      default:  cmd_vld = 1'b0;
    endcase
  end

  assign full        = q_full;
  assign q_push      = push && !q_full && cmd_vld;
  assign q_data.kind = kind;
  assign q_data.data = in_write_data;

endmodule

>>> rtl/rtcrf_back.sv
// Back end: register file, user RAM, calendar counters and read pipeline.
module rtcrf_back #(
  parameter int ADDRESS_SPACE = rtcrf_pkg::ADDRESS_SPACE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_empty,
  input  rtcrf_pkg::cmd_t               cmd_data,
  output logic                          cmd_pop,
  input  logic [rtcrf_pkg::RES_CNT_W-1:0] res_count,
  output logic                          res_push,
  output logic [7:0]                    res_data
);

  import rtcrf_pkg::*;

  localparam int RAM_DEPTH = ADDRESS_SPACE - RAM_BASE;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  logic [7:0] sel_r, sel_nxt;
  logic [7:0] sec_r, sec_nxt;
  logic [7:0] min_r, min_nxt;
  logic [7:0] hour_r, hour_nxt;
  logic [7:0] day_r, day_nxt;
  logic [7:0] mon_r, mon_nxt;
  logic [7:0] year_r, year_nxt;
  logic [7:0] wday_r, wday_nxt;
  logic [7:0] al0_r, al0_nxt;
  logic [7:0] al1_r, al1_nxt;
  logic [7:0] al2_r, al2_nxt;
  logic [7:0] ca_r, ca_nxt;
  logic [7:0] cb_r, cb_nxt;
  logic [7:0] fc_r, fc_nxt;
  logic [7:0] sd_r, sd_nxt;

  logic [7:0]     ram [RAM_DEPTH];
  logic           ram_vld_r [RAM_DEPTH];
  logic [7:0]     ram_q_r;
  logic           s2_vld_r, s2_vld_nxt;
  logic           s2_ram_r;
  logic           s2_ram_ok_r;
  logic [7:0]     s2_val_r;

  logic           issue;
  logic           dm;
  logic           in_map;
  logic           is_ram;
  logic [7:0]     ram_off;
  logic [RAM_AW-1:0] ram_addr;
  logic           ram_we;
  logic           ram_re;
  logic [7:0]     reg_rd;
  logic [7:0]     rd_val;
  logic [7:0]     wr_take;

  logic [7:0]     t_sec, t_min, t_hour, t_day, t_mon, t_year, t_wday;
  logic [4:0]     mlen;
  logic [2:0]     mterm, yterm;
  logic [5:0]     zsum;

  assign issue   = !cmd_empty &&
                   (({1'b0, res_count} + (RES_CNT_W + 1)'(s2_vld_r)) <
                    (RES_CNT_W + 1)'(RES_DEPTH));
  assign cmd_pop = issue;
  assign dm      = cb_r[DM_BIT];
  assign in_map  = ({1'b0, sel_r} < 9'(ADDRESS_SPACE));
  assign is_ram  = in_map && (sel_r >= 8'(RAM_BASE));
  assign ram_off = sel_r - 8'(RAM_BASE);
  assign ram_addr = ram_off[RAM_AW-1:0];
  assign ram_we  = issue && is_ram && (cmd_data.kind == CMD_WR_DATA);
  assign ram_re  = issue && is_ram && (cmd_data.kind == CMD_RD_DATA);
  assign wr_take = dm ? cmd_data.data : from_bcd(cmd_data.data);

  always_comb begin
    unique case (sel_r)
      REG_SEC:     reg_rd = dm ? sec_r : to_bcd(sec_r);
      REG_SEC_AL:  reg_rd = al0_r;
      REG_MIN:     reg_rd = dm ? min_r : to_bcd(min_r);
      REG_MIN_AL:  reg_rd = al1_r;
      REG_HOUR:    reg_rd = dm ? hour_r : to_bcd(hour_r);
      REG_HOUR_AL: reg_rd = al2_r;
      REG_WDAY:    reg_rd = wday_r;
      REG_DAY:     reg_rd = dm ? day_r : to_bcd(day_r);
      REG_MONTH:   reg_rd = dm ? mon_r : to_bcd(mon_r);
      REG_YEAR:    reg_rd = dm ? year_r : to_bcd(year_r);
      REG_A:       reg_rd = ca_r;
      REG_B:       reg_rd = cb_r;
      REG_C:       reg_rd = fc_r;
      REG_D:       reg_rd = sd_r;
      default:     reg_rd = READ_FILL;
    endcase
  end

  assign rd_val = (cmd_data.kind == CMD_RD_DATA) ? reg_rd : READ_FILL;

  // month length
  always_comb begin
    unique case (mon_r)
      8'd2:                        mlen = leap_year(year_r) ? 5'd29 : 5'd28;
      8'd4, 8'd6, 8'd9, 8'd11:     mlen = 5'd30;
      default:                     mlen = 5'd31;
    endcase
  end

  // one-second advance
  always_comb begin
    t_sec  = sec_r + 8'd1;
    t_min  = min_r;
    t_hour = hour_r;
    t_day  = day_r;
    t_mon  = mon_r;
    t_year = year_r;
    if (sec_r >= 8'd59) begin
      t_sec = '0;
      t_min = min_r + 8'd1;
      if (min_r >= 8'd59) begin
        t_min  = '0;
        t_hour = hour_r + 8'd1;
        if (hour_r >= 8'd23) begin
          t_hour = '0;
          t_day  = day_r + 8'd1;
          if (day_r >= 8'(mlen)) begin
            t_day = 8'd1;
            t_mon = mon_r + 8'd1;
            if (mon_r >= 8'd12) begin
              t_mon  = 8'd1;
              t_year = year_r + 8'd1;
            end
          end
        end
      end
    end
    mterm  = MONTH_TAB[t_mon];
    yterm  = (t_mon < 8'd3) ? YEAR_TAB_DEC[t_year] : YEAR_TAB[t_year];
    zsum   = 6'(t_day[4:0]) + 6'(mterm) + 6'(yterm);
    t_wday = ((sec_r >= 8'd59) && (min_r >= 8'd59) && (hour_r >= 8'd23)) ?
             8'(MOD7_TAB[zsum]) : wday_r;
  end

  always_comb begin
    sel_nxt    = sel_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    year_nxt   = year_r;
    wday_nxt   = wday_r;
    al0_nxt    = al0_r;
    al1_nxt    = al1_r;
    al2_nxt    = al2_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    fc_nxt     = fc_r;
    sd_nxt     = sd_r;
    s2_vld_nxt = 1'b0;
    if (issue) begin
      unique case (cmd_data.kind)
        CMD_RD_DATA: begin
          s2_vld_nxt = 1'b1;
          fc_nxt     = fc_r & FLAGS_KEEP;
        end
        CMD_RD_INDEX: begin
          s2_vld_nxt = 1'b1;
        end
        CMD_WR_INDEX: begin
          sel_nxt = cmd_data.data;
        end
        CMD_WR_DATA: begin
          unique case (sel_r)
            REG_SEC:     sec_nxt  = wr_take;
            REG_SEC_AL:  al0_nxt  = cmd_data.data;
            REG_MIN:     min_nxt  = wr_take;
            REG_MIN_AL:  al1_nxt  = cmd_data.data;
            REG_HOUR:    hour_nxt = wr_take;
            REG_HOUR_AL: al2_nxt  = cmd_data.data;
            REG_WDAY:    wday_nxt = cmd_data.data;
            REG_DAY:     day_nxt  = wr_take;
            REG_MONTH:   mon_nxt  = wr_take;
            REG_YEAR:    year_nxt = wr_take;
            REG_A:       ca_nxt   = cmd_data.data;
            REG_B:       cb_nxt   = cmd_data.data;
            REG_C:       fc_nxt   = cmd_data.data;
            REG_D:       sd_nxt   = cmd_data.data;
            default:     ;
          endcase
        end
        CMD_TICK: begin
          sec_nxt  = t_sec;
          min_nxt  = t_min;
          hour_nxt = t_hour;
          day_nxt  = t_day;
          mon_nxt  = t_mon;
          year_nxt = t_year;
          wday_nxt = t_wday;
          fc_nxt   = fc_r | (8'd1 << PF_BIT);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= '0;
      sec_r    <= '0;
      min_r    <= '0;
      hour_r   <= '0;
      day_r    <= 8'd1;
      mon_r    <= 8'd1;
      year_r   <= '0;
      wday_r   <= '0;
      al0_r    <= '0;
      al1_r    <= '0;
      al2_r    <= '0;
      ca_r     <= '0;
      cb_r     <= CTRL_B_RST;
      fc_r     <= '0;
      sd_r     <= STAT_D_RST;
      s2_vld_r <= 1'b0;
    end else begin
      sel_r    <= sel_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hour_r   <= hour_nxt;
      day_r    <= day_nxt;
      mon_r    <= mon_nxt;
      year_r   <= year_nxt;
      wday_r   <= wday_nxt;
      al0_r    <= al0_nxt;
      al1_r    <= al1_nxt;
      al2_r    <= al2_nxt;
      ca_r     <= ca_nxt;
      cb_r     <= cb_nxt;
      fc_r     <= fc_nxt;
      sd_r     <= sd_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) begin
        ram_vld_r[i] <= 1'b0;
      end
    end else if (ram_we) begin
      ram_vld_r[ram_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[ram_addr] <= cmd_data.data;
    end
    if (ram_re) begin
      ram_q_r <= ram[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_ram_r    <= ram_re;
      s2_ram_ok_r <= ram_vld_r[ram_addr];
      s2_val_r    <= rd_val;
    end
  end

  assign res_push = s2_vld_r;
  assign res_data = s2_ram_r ? (s2_ram_ok_r ? ram_q_r : 8'h00) : s2_val_r;

endmodule

>>> rtl/rtc_register_file_with_calendar.sv
// Top level: real-time clock register file with calendar behind an index/data port pair.
//
// Input channel: push/full with in_operation, in_port, in_write_data. A beat is
// taken on a clock edge with push high and full low; one beat per cycle is sustained
// while the result queue is drained. Reads, index and data writes, and one-second
// ticks share this channel. Result channel: empty/pop with out_read_data. Only reads
// produce a result beat, in the order of the reads; it is taken on an edge with pop
// high and empty low. A read passes through the command queue, the execute stage with
// its RAM read and the result queue, each registered. Throughput: one beat per cycle
// while the result queue has room, set by the single execute stage in the back end.
// A stalled receiver fills the result queue; the back end then holds commands,
// the command queue fills and full rises. Nothing is dropped.
// Reset (rst_n low, synchronous) returns the time to 2000-01-01 00:00:00,
// Saturday, register B to 0x03, register D to 0x80, clears the user RAM
// (valid bits) and empties both queues.
module rtc_register_file_with_calendar #(
  parameter int ADDRESS_SPACE = rtcrf_pkg::ADDRESS_SPACE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_operation,
  input  logic [1:0] in_port,
  input  logic [7:0] in_write_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_read_data
);

  import rtcrf_pkg::*;

  logic                 q_push;
  logic                 q_full;
  cmd_t                 q_wdata;
  cmd_t                 q_rdata;
  logic                 q_empty;
  logic                 q_pop;
  logic [$clog2(CMD_DEPTH+1)-1:0] q_count;
  logic                 res_push;
  logic [7:0]           res_data;
  logic                 res_full;
  logic [RES_CNT_W-1:0] res_count;

  rtcrf_front u_front (
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_port       (in_port),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  rtcrf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  rtcrf_back #(
    .ADDRESS_SPACE (ADDRESS_SPACE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd_data  (q_rdata),
    .cmd_pop   (q_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  rtcrf_fifo #(
    .WIDTH (8),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_read_data),
    .empty (empty),
    .count (res_count)
  );

endmodule
